>>> rtl/core/mandelbrot_escape_time_macros.svh
// Assertion macros for the Mandelbrot escape-time core.
// Each macro expects clk and rst in scope; the bodies are empty under SYNTHESIS.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every edge out of reset.
`define MBE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition in one cycle implies the consequent in the next.
`define MBE_ASSERT_NEXT(name, cond, conseq, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);
`else
`define MBE_ASSERT(name, prop, msg)
`define MBE_ASSERT_NEXT(name, cond, conseq, msg)
`endif

`endif

>>> rtl/core/mbe_pkg.sv
// Shared widths, constants, types and saturation helper for the escape-time core.
// No dependencies.
package mbe_pkg;

  localparam int COORD_BITS    = 32;
  localparam int FRAC_BITS     = 28;
  localparam int COUNT_BITS    = 16;
  localparam int GRID_DIM_BITS = 12;
  localparam int DIM_REG_BITS  = 13;
  localparam int CFG_IDX_BITS  = 3;

  // divider: quotient magnitude bits, one chain cell per bit
  localparam int DIV_BITS  = COORD_BITS;
  localparam int STEP_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = GRID_DIM_BITS + 1 + STEP_BITS;
  localparam int SAT_BITS  = 2 * COORD_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COUNT_BITS-1:0]        count_t;
  typedef logic [DIM_REG_BITS-1:0]      dim_t;
  typedef logic signed [STEP_BITS-1:0]  step_t;

  // 4.0 in the squared (Q8.56) format
  localparam logic [2*COORD_BITS-1:0] MAG_LIMIT = (2*COORD_BITS)'(4) << (2 * FRAC_BITS);

  localparam coord_t RST_REAL_LOW  = -coord_t'(2) <<< FRAC_BITS;
  localparam coord_t RST_REAL_HIGH = coord_t'(1) <<< FRAC_BITS;
  localparam coord_t RST_IMAG_LOW  = -coord_t'(1) <<< FRAC_BITS;
  localparam coord_t RST_IMAG_HIGH = coord_t'(1) <<< FRAC_BITS;
  localparam dim_t   RST_WIDTH     = dim_t'(640);
  localparam dim_t   RST_HEIGHT    = dim_t'(480);
  localparam count_t RST_LIMIT     = count_t'(256);

  localparam logic [CFG_IDX_BITS-1:0] REG_REAL_LOW  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_REAL_HIGH = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAG_LOW  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAG_HIGH = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT     = 3'd6;

  localparam logic TAG_REAL = 1'b0;
  localparam logic TAG_IMAG = 1'b1;

  // one divider cell's payload; word holds remaining dividend bits above quotient bits
  typedef struct packed {
    logic                    valid;
    logic                    tag;
    logic                    neg;
    logic [DIV_BITS-1:0]     word;
    logic [DIM_REG_BITS-1:0] rem;
    logic [DIM_REG_BITS-1:0] dvs;
  } div_stage_t;

  typedef struct packed {
    logic  valid;
    logic  tag;
    step_t dividend;
    dim_t  divisor;
  } div_req_t;

  typedef struct packed {
    logic  valid;
    logic  tag;
    step_t quotient;
  } div_rsp_t;

  typedef struct packed {
    logic load;
    logic advance;
  } iter_ctrl_t;

  typedef struct packed {
    logic   done;
    count_t count;
  } iter_status_t;

  function automatic coord_t sat_coord(input logic signed [SAT_BITS-1:0] v);
    logic signed [SAT_BITS-1:0] hi_lim;
    logic signed [SAT_BITS-1:0] lo_lim;
    hi_lim = {{(SAT_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    lo_lim = ~hi_lim;
    if (v > hi_lim) begin
      return hi_lim[COORD_BITS-1:0];
    end else if (v < lo_lim) begin
      return lo_lim[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

endpackage

>>> rtl/core/mbe_div_cell.sv
// One restoring-division cell: produces one quotient bit and hands on the remainder.
// Depends on mbe_pkg.
module mbe_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  mbe_pkg::div_stage_t din,
  output mbe_pkg::div_stage_t dout
);
  import mbe_pkg::*;

  logic [DIM_REG_BITS:0]   trial;
  logic                    ge;
  logic [DIM_REG_BITS:0]   diff;
  div_stage_t              nxt;

  always_comb begin
    trial    = {din.rem, din.word[DIV_BITS-1]};
    ge       = trial >= {1'b0, din.dvs};
    diff     = trial - {1'b0, din.dvs};
    nxt      = din;
    nxt.rem  = ge ? diff[DIM_REG_BITS-1:0] : trial[DIM_REG_BITS-1:0];
    nxt.word = {din.word[DIV_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout <= nxt;
    end
  end

endmodule

>>> rtl/core/mbe_div_chain.sv
// Row of division cells: signed step = dividend / divisor, truncated toward zero.
// One request may enter per cycle; each cell is a register. Depends on mbe_pkg, mbe_div_cell.
`include "mandelbrot_escape_time_macros.svh"

module mbe_div_chain (
  input  logic             clk,
  input  logic             rst,
  input  mbe_pkg::div_req_t req,
  output mbe_pkg::div_rsp_t rsp
);
  import mbe_pkg::*;

  div_stage_t           stage [0:DIV_BITS];
  logic [STEP_BITS-1:0] mag_in;
  logic [STEP_BITS-1:0] mag_q;

  // sign-magnitude front end; a zero divisor counts as one
  always_comb begin
    mag_in         = req.dividend[STEP_BITS-1] ? -req.dividend : req.dividend;
    stage[0].valid = req.valid;
    stage[0].tag   = req.tag;
    stage[0].neg   = req.dividend[STEP_BITS-1];
    stage[0].word  = mag_in[DIV_BITS-1:0];
    stage[0].rem   = '0;
    stage[0].dvs   = (req.divisor == '0) ? dim_t'(1) : req.divisor;
  end

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_cell
    mbe_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (stage[i]),
      .dout (stage[i+1])
    );
  end

  always_comb begin
    mag_q        = {1'b0, stage[DIV_BITS].word};
    rsp.valid    = stage[DIV_BITS].valid;
    rsp.tag      = stage[DIV_BITS].tag;
    rsp.quotient = stage[DIV_BITS].neg ? -mag_q : mag_q;
  end

  `MBE_ASSERT(a_div_latency, req.valid |-> ##DIV_BITS rsp.valid, "divider lost a request")
  `MBE_ASSERT(a_div_rem,
              stage[DIV_BITS].valid |-> (stage[DIV_BITS].rem < stage[DIV_BITS].dvs),
              "divider remainder not below divisor")

endmodule

>>> rtl/core/mbe_iter.sv
// Escape-time loop: holds z, c and the update count, one z = z*z + c per cycle
// while advancing, until done. Escape test uses the squares of the newest z. Depends on mbe_pkg.
`include "mandelbrot_escape_time_macros.svh"

module mbe_iter (
  input  logic                 clk,
  input  logic                 rst,
  input  mbe_pkg::iter_ctrl_t  ctrl,
  input  mbe_pkg::coord_t      c_re,
  input  mbe_pkg::coord_t      c_im,
  input  mbe_pkg::count_t      limit,
  output mbe_pkg::iter_status_t status
);
  import mbe_pkg::*;

  coord_t zr, zi, cr, ci;
  count_t k;

  logic signed [2*COORD_BITS-1:0] xx, yy, xy, diff;
  logic signed [SAT_BITS-1:0]     re_sum, im_sum;
  logic [2*COORD_BITS-1:0]        mag;
  coord_t                         nr, ni;
  logic                           escaped;
  logic                           at_limit;

  always_comb begin
    xx     = (2*COORD_BITS)'(zr) * (2*COORD_BITS)'(zr);
    yy     = (2*COORD_BITS)'(zi) * (2*COORD_BITS)'(zi);
    xy     = (2*COORD_BITS)'(zr) * (2*COORD_BITS)'(zi);
    diff   = xx - yy;
    re_sum = SAT_BITS'(diff >>> FRAC_BITS) + SAT_BITS'(cr);
    im_sum = SAT_BITS'(xy >>> (FRAC_BITS - 1)) + SAT_BITS'(ci);
    nr     = sat_coord(re_sum);
    ni     = sat_coord(im_sum);
    mag    = $unsigned(xx) + $unsigned(yy);
    // z holds c before the first update, so no test at k == 0
    escaped  = (k != '0) && (mag > MAG_LIMIT);
    at_limit = (k == limit);
    status.done  = escaped || at_limit;
    status.count = escaped ? (k - count_t'(1)) : limit;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      zr <= c_re;
      zi <= c_im;
      cr <= c_re;
      ci <= c_im;
      k  <= '0;
    end else if (ctrl.advance && !status.done) begin
      zr <= nr;
      zi <= ni;
      k  <= k + count_t'(1);
    end
  end

  `MBE_ASSERT(a_iter_bound, ctrl.advance |-> (k <= limit), "update count ran past limit")

endmodule

>>> rtl/core/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time core: config registers, sequencer,
// coordinate mapping. Depends on mbe_pkg, mbe_div_chain, mbe_iter.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    pixel request: column, row
//  m_*      out  m_tvalid/m_tready    escape count
//  cfg_*    in   cfg_wen              register write, index + data
//
// An accepted request feeds the real and then the imaginary step through the
// 32-cell divider chain; each product is registered, the mapped c loads z, then
// one z update per cycle until the pixel escapes or reaches iteration_limit.
// One pixel is in work at a time; s_tready is high only while idle.
// rst is synchronous; it restores the default view and limit.
// A result waiting on m_tready holds the finished pixel until the output frees.
`include "mandelbrot_escape_time_macros.svh"

module mandelbrot_escape_time (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [23:0]                       s_tdata,   // [11:0] pixel_column, [23:12] pixel_row
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,   // [15:0] escape_count
  input  logic                              cfg_wen,
  input  logic [mbe_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mbe_pkg::COORD_BITS-1:0]    cfg_wdata
);
  import mbe_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FEED = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_ITER = 3'd4;

  logic [2:0] state, state_next;

  coord_t real_low, real_high, imag_low, imag_high;
  dim_t   grid_width, grid_height;
  count_t iteration_limit;

  logic [GRID_DIM_BITS-1:0]     col, row;
  logic signed [PROD_BITS-1:0]  prod_re, prod_im;
  logic signed [PROD_BITS-1:0]  mult;
  logic [GRID_DIM_BITS-1:0]     idx;

  div_req_t     div_req;
  div_rsp_t     div_rsp;
  iter_ctrl_t   ictrl;
  iter_status_t istat;
  coord_t       c_re, c_im;
  logic         accept;
  logic         result_we;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign result_we = (state == ST_ITER) && istat.done && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      real_low        <= RST_REAL_LOW;
      real_high       <= RST_REAL_HIGH;
      imag_low        <= RST_IMAG_LOW;
      imag_high       <= RST_IMAG_HIGH;
      grid_width      <= RST_WIDTH;
      grid_height     <= RST_HEIGHT;
      iteration_limit <= RST_LIMIT;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_REAL_LOW:  real_low        <= cfg_wdata;
        REG_REAL_HIGH: real_high       <= cfg_wdata;
        REG_IMAG_LOW:  imag_low        <= cfg_wdata;
        REG_IMAG_HIGH: imag_high       <= cfg_wdata;
        REG_WIDTH:     grid_width      <= cfg_wdata[DIM_REG_BITS-1:0];
        REG_HEIGHT:    grid_height     <= cfg_wdata[DIM_REG_BITS-1:0];
        REG_LIMIT:     iteration_limit <= cfg_wdata[COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col <= s_tdata[GRID_DIM_BITS-1:0];
      row <= s_tdata[2*GRID_DIM_BITS-1:GRID_DIM_BITS];
    end
  end

  // real step goes in with the request, imaginary step in the following cycle
  always_comb begin
    div_req.valid = accept || (state == ST_FEED);
    if (state == ST_FEED) begin
      div_req.tag      = TAG_IMAG;
      div_req.dividend = STEP_BITS'(imag_high) - STEP_BITS'(imag_low);
      div_req.divisor  = grid_height;
    end else begin
      div_req.tag      = TAG_REAL;
      div_req.dividend = STEP_BITS'(real_high) - STEP_BITS'(real_low);
      div_req.divisor  = grid_width;
    end
  end

  mbe_div_chain u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // index * step; responses come one at a time so the multiplier is shared
  always_comb begin
    idx  = (div_rsp.tag == TAG_IMAG) ? row : col;
    mult = PROD_BITS'($signed({1'b0, idx})) * PROD_BITS'(div_rsp.quotient);
  end

  always_ff @(posedge clk) begin
    if (div_rsp.valid) begin
      if (div_rsp.tag == TAG_IMAG) begin
        prod_im <= mult;
      end else begin
        prod_re <= mult;
      end
    end
  end

  always_comb begin
    c_re = sat_coord(SAT_BITS'(real_low) + SAT_BITS'(prod_re));
    c_im = sat_coord(SAT_BITS'(imag_low) + SAT_BITS'(prod_im));
    ictrl.load    = (state == ST_LOAD);
    ictrl.advance = (state == ST_ITER);
  end

  mbe_iter u_iter (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ictrl),
    .c_re   (c_re),
    .c_im   (c_im),
    .limit  (iteration_limit),
    .status (istat)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_FEED;
      ST_FEED: state_next = ST_DIV;
      ST_DIV:  if (div_rsp.valid && div_rsp.tag == TAG_IMAG) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_ITER;
      ST_ITER: if (result_we) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (result_we) begin
        m_tvalid <= 1'b1;
        m_tdata  <= istat.count;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `MBE_ASSERT(a_div_rsp_state,
              div_rsp.valid |-> (state == ST_DIV),
              "divider response outside wait state")
  `MBE_ASSERT_NEXT(a_result_hold,
                   (state == ST_ITER) && istat.done && m_tvalid && !m_tready,
                   state == ST_ITER,
                   "finished pixel dropped while output stalled")

endmodule

>>> sim/escape_count_checker.sv
// Checker for the Mandelbrot escape-time core: mirrors the register file,
// predicts each pixel's escape count and compares it with the output stream.
// Depends on mbe_pkg for widths, register indexes and reset values.
module escape_count_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [23:0]                      s_tdata,   // [11:0] pixel_column, [23:12] pixel_row
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [15:0]                      m_tdata,   // [15:0] escape_count
  input  logic                             cfg_wen,
  input  logic [mbe_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [mbe_pkg::COORD_BITS-1:0]   cfg_wdata,
  output int                               pending,
  output int                               errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import mbe_pkg::*;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  coord_t view_real_low  = RST_REAL_LOW;
  coord_t view_real_high = RST_REAL_HIGH;
  coord_t view_imag_low  = RST_IMAG_LOW;
  coord_t view_imag_high = RST_IMAG_HIGH;
  dim_t   view_width     = RST_WIDTH;
  dim_t   view_height    = RST_HEIGHT;
  count_t iter_cap       = RST_LIMIT;

  count_t expected_counts[$];
  count_t want;

  initial begin
    pending = 0;
    errors  = 0;
  end

  function automatic coord_t coord_clamp(input longint v);
    if (v > Q_MAX) return coord_t'(Q_MAX);
    if (v < Q_MIN) return coord_t'(Q_MIN);
    return coord_t'(v);
  endfunction

  // low + idx * ((high - low) / dim), divide truncates toward zero
  function automatic coord_t axis_point(input coord_t lo, input coord_t hi,
                                        input dim_t dim, input logic [11:0] idx);
    longint divisor;
    longint step;
    divisor = (dim == '0) ? 64'sd1 : longint'(dim);
    step    = (longint'(hi) - longint'(lo)) / divisor;
    return coord_clamp(longint'(lo) + longint'(idx) * step);
  endfunction

  function automatic count_t escape_count_for(input logic [11:0] col,
                                              input logic [11:0] row);
    coord_t      cr;
    coord_t      ci;
    coord_t      zr;
    coord_t      zi;
    longint      xx;
    longint      yy;
    longint      xy;
    logic [63:0] sq_r;
    logic [63:0] sq_i;
    int          i;
    cr = axis_point(view_real_low, view_real_high, view_width, col);
    ci = axis_point(view_imag_low, view_imag_high, view_height, row);
    zr = cr;
    zi = ci;
    for (i = 0; i < int'(iter_cap); i++) begin
      xx = longint'(zr) * longint'(zr);
      yy = longint'(zi) * longint'(zi);
      xy = longint'(zr) * longint'(zi);
      // arithmetic shift rounds toward minus infinity; 2xy via one less shift
      zr = coord_clamp(((xx - yy) >>> FRAC_BITS) + longint'(cr));
      zi = coord_clamp((xy >>> (FRAC_BITS - 1)) + longint'(ci));
      sq_r = longint'(zr) * longint'(zr);
      sq_i = longint'(zi) * longint'(zi);
      if (sq_r + sq_i > MAG_LIMIT) break;
    end
    return count_t'(i);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      view_real_low  = RST_REAL_LOW;
      view_real_high = RST_REAL_HIGH;
      view_imag_low  = RST_IMAG_LOW;
      view_imag_high = RST_IMAG_HIGH;
      view_width     = RST_WIDTH;
      view_height    = RST_HEIGHT;
      iter_cap       = RST_LIMIT;
      expected_counts.delete();
      pending <= 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_REAL_LOW:  view_real_low  = coord_t'(cfg_wdata);
          REG_REAL_HIGH: view_real_high = coord_t'(cfg_wdata);
          REG_IMAG_LOW:  view_imag_low  = coord_t'(cfg_wdata);
          REG_IMAG_HIGH: view_imag_high = coord_t'(cfg_wdata);
          REG_WIDTH:     view_width     = cfg_wdata[DIM_REG_BITS-1:0];
          REG_HEIGHT:    view_height    = cfg_wdata[DIM_REG_BITS-1:0];
          REG_LIMIT:     iter_cap       = cfg_wdata[COUNT_BITS-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        expected_counts.push_back(escape_count_for(s_tdata[11:0], s_tdata[23:12]));
      end
      if (m_tvalid && m_tready) begin
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("escape_count %0d with no request outstanding",
                                    m_tdata));
        end else begin
          want = expected_counts.pop_front();
          if (m_tdata !== want) begin
            report_mismatch($sformatf("escape_count got %0d want %0d", m_tdata, want));
          end
        end
      end
      pending <= pending + ((s_tvalid && s_tready) ? 1 : 0)
                         - ((m_tvalid && m_tready) ? 1 : 0);
    end
  end

endmodule

>>> sim/tb_mandelbrot_escape_time.sv
// Testbench top for the Mandelbrot escape-time core: reset, register setups,
// pixel requests with random gaps and output stalls, and the verdict.
// Depends on mbe_pkg, mandelbrot_escape_time and escape_count_checker.
module tb_mandelbrot_escape_time;
  timeunit 1ns;
  timeprecision 1ps;
  import mbe_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam coord_t COORD_MAX   = 32'sh7fffffff;
  localparam coord_t COORD_MIN   = 32'sh80000000;
  localparam int     CYCLE_LIMIT = 3000000;
  localparam int     TAIL_CYCLES = 40;

  typedef struct {
    coord_t real_low;
    coord_t real_high;
    coord_t imag_low;
    coord_t imag_high;
    dim_t   width;
    dim_t   height;
    count_t limit;
  } view_t;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [23:0]             s_tdata   = '0;   // [11:0] pixel_column, [23:12] pixel_row
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [15:0]             m_tdata;          // [15:0] escape_count
  logic                    cfg_wen   = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COORD_BITS-1:0]   cfg_wdata = '0;

  int    pending;
  int    errors;
  int    cycle_count = 0;
  int    stall_left  = 0;
  int    stall_draw;
  bit    tx_quiet    = 1'b0;
  bit    rx_quiet    = 1'b0;
  view_t cur;

  mandelbrot_escape_time uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  escape_count_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pending   (pending),
    .errors    (errors)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // output side: after each result, hold m_tready low for a randomly drawn stall
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
      stall_draw = rx_quiet ? 0 : $urandom_range(0, 7);
      stall_left <= stall_draw;
      m_tready   <= (stall_draw == 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= (stall_left == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic cfg_put(input logic [CFG_IDX_BITS-1:0] idx,
                         input logic [COORD_BITS-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic program_view(input view_t v, input bit poke_unused);
    cfg_put(REG_REAL_LOW,  v.real_low);
    cfg_put(REG_REAL_HIGH, v.real_high);
    cfg_put(REG_IMAG_LOW,  v.imag_low);
    cfg_put(REG_IMAG_HIGH, v.imag_high);
    cfg_put(REG_WIDTH,     COORD_BITS'(v.width));
    cfg_put(REG_HEIGHT,    COORD_BITS'(v.height));
    cfg_put(REG_LIMIT,     COORD_BITS'(v.limit));
    // write to an unmapped index must leave everything alone
    if (poke_unused) cfg_put(REG_UNUSED, $urandom);
    cfg_wen <= 1'b0;
  endtask

  // one pixel request; s_tvalid stays high into the next request when no gap
  task automatic run_pixel(input logic [11:0] col, input logic [11:0] row);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {row, col};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic finish_phase();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly inside the grid, sometimes anywhere in the 12-bit range
  function automatic logic [11:0] pick_index(input dim_t dim);
    int extent;
    extent = (dim == '0) ? 1 : ((dim > 4096) ? 4096 : int'(dim));
    if ($urandom_range(0, 3) != 0) return 12'($urandom_range(0, extent - 1));
    return 12'($urandom_range(0, 4095));
  endfunction

  task automatic random_pixels(input int count);
    repeat (count) run_pixel(pick_index(cur.width), pick_index(cur.height));
  endtask

  function automatic view_t random_view(input bit wild);
    view_t v;
    if (wild) begin
      v.real_low  = coord_t'($urandom);
      v.real_high = coord_t'($urandom);
      v.imag_low  = coord_t'($urandom);
      v.imag_high = coord_t'($urandom);
      v.width     = dim_t'($urandom_range(0, 8191));
      v.height    = dim_t'($urandom_range(0, 8191));
      v.limit     = count_t'($urandom_range(0, 200));
    end else begin
      // window's low corner somewhere over the set, real -2.5..0.5, imag -1.5..0.5
      v.real_low  = coord_t'(-671088640 + int'($urandom_range(0, 805306368)));
      v.real_high = v.real_low + coord_t'($urandom_range(65536, 805306368));
      v.imag_low  = coord_t'(-402653184 + int'($urandom_range(0, 536870912)));
      v.imag_high = v.imag_low + coord_t'($urandom_range(65536, 536870912));
      v.width     = dim_t'($urandom_range(1, 4096));
      v.height    = dim_t'($urandom_range(1, 4096));
      v.limit     = count_t'($urandom_range(16, 512));
    end
    return v;
  endfunction

  initial begin
    cur.real_low  = RST_REAL_LOW;
    cur.real_high = RST_REAL_HIGH;
    cur.imag_low  = RST_IMAG_LOW;
    cur.imag_high = RST_IMAG_HIGH;
    cur.width     = RST_WIDTH;
    cur.height    = RST_HEIGHT;
    cur.limit     = RST_LIMIT;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset view: corners, extrapolated index, c = -2 on the boundary, inside point
    run_pixel(12'd0, 12'd0);
    run_pixel(12'd4095, 12'd4095);
    run_pixel(12'd639, 12'd479);
    run_pixel(12'd639, 12'd0);
    run_pixel(12'd0, 12'd240);
    run_pixel(12'd320, 12'd240);
    run_pixel(12'd160, 12'd120);
    random_pixels(100);
    finish_phase();

    // zero iteration limit: every count is 0
    cur.limit = '0;
    program_view(cur, 1'b1);
    run_pixel(12'd0, 12'd0);
    run_pixel(12'd4095, 12'd4095);
    random_pixels(20);
    finish_phase();

    // zero dimensions act as one, single update
    cur.width  = '0;
    cur.height = '0;
    cur.limit  = count_t'(1);
    program_view(cur, 1'b0);
    random_pixels(10);
    finish_phase();

    // reversed edges, dimensions of 4096 and past it
    cur.real_low  = RST_REAL_HIGH;
    cur.real_high = RST_REAL_LOW;
    cur.imag_low  = RST_IMAG_HIGH;
    cur.imag_high = RST_IMAG_LOW;
    cur.width     = dim_t'(8191);
    cur.height    = dim_t'(4096);
    cur.limit     = count_t'(64);
    program_view(cur, 1'b0);
    run_pixel(12'd0, 12'd0);
    run_pixel(12'd4095, 12'd0);
    random_pixels(60);
    finish_phase();

    // full-range edges over one pixel: coordinates and z saturate
    cur.real_low  = COORD_MIN;
    cur.real_high = COORD_MAX;
    cur.imag_low  = COORD_MIN;
    cur.imag_high = COORD_MAX;
    cur.width     = dim_t'(1);
    cur.height    = dim_t'(1);
    cur.limit     = count_t'(300);
    program_view(cur, 1'b1);
    run_pixel(12'd0, 12'd0);
    run_pixel(12'd1, 12'd0);
    run_pixel(12'd4095, 12'd4095);
    random_pixels(30);
    finish_phase();

    for (int p = 0; p < 5; p++) begin
      cur = random_view(p % 2 == 1);
      program_view(cur, p == 0);
      random_pixels(60);
      finish_phase();
    end

    // largest limit on a coarse grid; (8,8) sits next to the origin
    cur.real_low  = COORD_MIN;
    cur.real_high = COORD_MAX;
    cur.imag_low  = COORD_MIN;
    cur.imag_high = COORD_MAX;
    cur.width     = dim_t'(16);
    cur.height    = dim_t'(16);
    cur.limit     = count_t'(65535);
    program_view(cur, 1'b0);
    run_pixel(12'd8, 12'd8);
    run_pixel(12'd0, 12'd0);
    run_pixel(12'd15, 12'd15);
    random_pixels(2);
    finish_phase();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
